// ===== src/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfe_pkg: shared types and constants of the meter frame encoder
// Frame marks, configuration register indexes, queue entry and the
// back-end sequencing phases.
// ----------------------------------------------------------------------------
`default_nettype none

package mfe_pkg;

  // frame marks
  localparam logic [7:0] START_MARK  = 8'h68;
  localparam logic [7:0] DATA_OFFSET = 8'h33;
  localparam logic [7:0] END_MARK    = 8'h16;
  localparam logic [7:0] LEADER_BYTE = 8'hFE;

  // configuration
  localparam int         ADDR_W      = 48;
  localparam int         PRE_W       = 3;
  localparam int         CFG_IDX_W   = 1;
  localparam logic [PRE_W-1:0] MAX_LEADERS   = 3'd4;
  localparam logic [PRE_W-1:0] PREAMBLE_RST  = 3'd4;
  localparam logic [2:0]       LAST_ADDR_IDX = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_COUNT = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // position of a body byte inside its frame
  typedef enum logic [1:0] {
    POS_CTRL,
    POS_LEN,
    POS_DATA
  } pos_t;

  // classified body item
  typedef struct packed {
    logic       first;
    logic [7:0] data;
    logic       last;
  } entry_t;

  // back-end emission phases
  typedef enum logic [2:0] {
    PH_NEW,
    PH_LEAD,
    PH_SOF1,
    PH_ADDR,
    PH_SOF2,
    PH_BODY,
    PH_SUM,
    PH_EOF
  } phase_t;

endpackage

`default_nettype wire

// ===== src/mfe_if.sv =====
// ----------------------------------------------------------------------------
// body_if / frame_if: valid-ready channels of the meter frame encoder
// Body bytes come in on body_if, frame bytes leave on frame_if.
// ----------------------------------------------------------------------------
`default_nettype none

interface body_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       is_last;

  modport source (output valid, output body_byte, output is_last, input ready);
  modport sink   (input valid, input body_byte, input is_last, output ready);
endinterface

interface frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/mfe_front.sv =====
// ----------------------------------------------------------------------------
// mfe_front: body item intake
// Tracks the position of each body byte in its frame, applies the data
// offset and pushes classified items into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_front (
  input  wire logic            clk,
  input  wire logic            rst,
  body_if.sink                 body,
  input  wire logic            q_ready,
  output logic                 push,
  output mfe_pkg::entry_t      push_entry
);

  mfe_pkg::pos_t pos;
  mfe_pkg::pos_t pos_next;

  // accept whenever the queue has room
  assign body.ready = q_ready;
  assign push       = body.valid && q_ready;

  // classify the byte and offset data bytes
  always_comb begin
    push_entry.first = (pos == mfe_pkg::POS_CTRL);
    push_entry.last  = body.is_last;
    if (pos == mfe_pkg::POS_DATA) begin
      push_entry.data = body.body_byte + mfe_pkg::DATA_OFFSET;
    end else begin
      push_entry.data = body.body_byte;
    end
  end

  // position advance, last mark restarts the frame
  always_comb begin
    pos_next = pos;
    if (push) begin
      if (body.is_last) begin
        pos_next = mfe_pkg::POS_CTRL;
      end else begin
        case (pos)
          mfe_pkg::POS_CTRL: pos_next = mfe_pkg::POS_LEN;
          mfe_pkg::POS_LEN:  pos_next = mfe_pkg::POS_DATA;
          mfe_pkg::POS_DATA: pos_next = mfe_pkg::POS_DATA;
          default:           pos_next = mfe_pkg::POS_CTRL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= mfe_pkg::POS_CTRL;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/mfe_queue.sv =====
// ----------------------------------------------------------------------------
// mfe_queue: short item queue between front and back
// Circular buffer of classified items with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_queue #(
  parameter int DEPTH = mfe_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mfe_pkg::entry_t push_entry,
  output logic                 ready,
  input  wire logic            pop,
  output logic                 head_valid,
  output mfe_pkg::entry_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mfe_pkg::entry_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign ready      = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // slot write
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mfe_back.sv =====
// ----------------------------------------------------------------------------
// mfe_back: frame byte sequencer
// Expands each queued item into its frame bytes: header ahead of the first
// body byte, checksum and end mark after the last, one byte per cycle into
// an output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire mfe_pkg::entry_t               head,
  output logic                               pop,
  input  wire logic [mfe_pkg::ADDR_W-1:0]    station_addr,
  input  wire logic [mfe_pkg::PRE_W-1:0]     preamble_count,
  frame_if.source                            frame
);

  mfe_pkg::phase_t phase;
  mfe_pkg::phase_t phase_next;
  mfe_pkg::phase_t cur;
  logic [2:0]      cnt;
  logic [2:0]      cnt_next;
  logic [7:0]      sum;
  logic [7:0]      sum_next;
  logic [mfe_pkg::PRE_W-1:0] lead;
  logic            fire;
  logic [7:0]      byte_sel;
  logic            end_sel;
  logic            summed;

  logic            out_valid;
  logic [7:0]      out_byte;
  logic            out_end;

  // leader count saturates
  assign lead = (preamble_count > mfe_pkg::MAX_LEADERS) ? mfe_pkg::MAX_LEADERS
                                                         : preamble_count;

  // a new item enters its first phase without a bubble
  always_comb begin
    cur = phase;
    if (phase == mfe_pkg::PH_NEW) begin
      if (!head.first) begin
        cur = mfe_pkg::PH_BODY;
      end else if (lead != '0) begin
        cur = mfe_pkg::PH_LEAD;
      end else begin
        cur = mfe_pkg::PH_SOF1;
      end
    end
  end

  assign fire = head_valid && (!out_valid || frame.ready);

  // byte selection, next phase and pop
  always_comb begin
    byte_sel   = head.data;
    end_sel    = 1'b0;
    summed     = 1'b0;
    phase_next = phase;
    cnt_next   = cnt;
    pop        = 1'b0;
    case (cur)
      mfe_pkg::PH_LEAD: begin
        byte_sel = mfe_pkg::LEADER_BYTE;
        if (cnt == lead - 3'd1) begin
          phase_next = mfe_pkg::PH_SOF1;
          cnt_next   = '0;
        end else begin
          phase_next = mfe_pkg::PH_LEAD;
          cnt_next   = cnt + 3'd1;
        end
      end
      mfe_pkg::PH_SOF1: begin
        byte_sel   = mfe_pkg::START_MARK;
        summed     = 1'b1;
        phase_next = mfe_pkg::PH_ADDR;
      end
      mfe_pkg::PH_ADDR: begin
        byte_sel = station_addr[{cnt, 3'b000} +: 8];
        summed   = 1'b1;
        if (cnt == mfe_pkg::LAST_ADDR_IDX) begin
          phase_next = mfe_pkg::PH_SOF2;
          cnt_next   = '0;
        end else begin
          cnt_next   = cnt + 3'd1;
        end
      end
      mfe_pkg::PH_SOF2: begin
        byte_sel   = mfe_pkg::START_MARK;
        summed     = 1'b1;
        phase_next = mfe_pkg::PH_BODY;
      end
      mfe_pkg::PH_BODY: begin
        byte_sel = head.data;
        summed   = 1'b1;
        if (head.last) begin
          phase_next = mfe_pkg::PH_SUM;
        end else begin
          phase_next = mfe_pkg::PH_NEW;
          pop        = fire;
        end
      end
      mfe_pkg::PH_SUM: begin
        byte_sel   = sum;
        phase_next = mfe_pkg::PH_EOF;
      end
      mfe_pkg::PH_EOF: begin
        byte_sel   = mfe_pkg::END_MARK;
        end_sel    = 1'b1;
        phase_next = mfe_pkg::PH_NEW;
        pop        = fire;
      end
      default: begin
        phase_next = mfe_pkg::PH_NEW;
      end
    endcase
    if (!fire) begin
      phase_next = phase;
      cnt_next   = cnt;
    end
  end

  // checksum restarts at the first start mark
  always_comb begin
    sum_next = sum;
    if (fire && summed) begin
      sum_next = ((cur == mfe_pkg::PH_SOF1) ? 8'h00 : sum) + byte_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mfe_pkg::PH_NEW;
      cnt   <= '0;
      sum   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      sum   <= sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte <= byte_sel;
      out_end  <= end_sel;
    end
  end

  assign frame.valid      = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.frame_end  = out_end;

endmodule

`default_nettype wire

// ===== src/meter_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// meter_frame_encoder: meter reply frame builder
// Wraps a stream of body bytes in preamble, start marks, address, checksum
// and end mark.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  body      in    valid / ready    body_byte[7:0], is_last
//  frame     out   valid / ready    frame_byte[7:0], frame_end
//  cfg       in    cfg_we           cfg_index[0], cfg_data[47:0]
//
//  A body byte is taken every cycle while the item queue has room.
//  The back sequencer emits one frame byte per cycle unless the output stalls:
//  header bytes before a control byte, checksum and end mark after a last one.
//  The queue of QUEUE_DEPTH items absorbs the header burst.
//  Reset is synchronous; no clearing pass. Output stalls hold the register.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_frame_encoder #(
  parameter int QUEUE_DEPTH = mfe_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  body_if.sink                                 body,
  frame_if.source                              frame,
  input  wire logic                            cfg_we,
  input  wire logic [mfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mfe_pkg::ADDR_W-1:0]      cfg_data
);

  logic [mfe_pkg::ADDR_W-1:0] station_addr;
  logic [mfe_pkg::PRE_W-1:0]  preamble_count;

  logic            q_ready;
  logic            push;
  mfe_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  mfe_pkg::entry_t head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      station_addr   <= '0;
      preamble_count <= mfe_pkg::PREAMBLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfe_pkg::CFG_STATION_ADDR:   station_addr   <= cfg_data;
        mfe_pkg::CFG_PREAMBLE_COUNT: preamble_count <= cfg_data[mfe_pkg::PRE_W-1:0];
        default: ;
      endcase
    end
  end

  mfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .body       (body),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  mfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mfe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .station_addr   (station_addr),
    .preamble_count (preamble_count),
    .frame          (frame)
  );

`ifndef NO_ASSERTIONS
  // the closing byte is always the end mark
  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.frame_end |-> frame.frame_byte == mfe_pkg::END_MARK)
    else $error("frame end flag on a byte other than the end mark");

  // an accepted item is visible at the queue head next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    body.valid && body.ready |=> head_valid)
    else $error("accepted item not in queue");

  // a queued item stays until the back pops it
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    head_valid && !pop |=> head_valid)
    else $error("queued item lost without pop");
`endif

endmodule

`default_nettype wire

// ===== sim/meter_frame_encoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_encoder_checker: frame prediction and scoreboard
// Watches the body, frame and register channels. Every accepted body item is
// expanded into the frame bytes it should produce: leaders, start marks,
// address, offset data, checksum and end mark. Each accepted frame byte is
// compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module meter_frame_encoder_checker
  import mfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  body_if                      body_mon,
  frame_if                     frame_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   bytes_checked,
  output int                   frames_closed
);

  typedef struct packed {
    logic [7:0] fbyte;
    logic       fend;
  } frame_out_t;

  // shadow registers and frame state
  logic [ADDR_W-1:0] addr_shadow;
  logic [PRE_W-1:0]  leaders_shadow;
  pos_t              body_pos;
  logic [7:0]        frame_sum;
  frame_out_t        frame_bytes_due[$];
  frame_out_t        want;

  task automatic due_plain(input logic [7:0] b, input logic fend);
    frame_out_t e;
    e.fbyte = b;
    e.fend  = fend;
    frame_bytes_due.push_back(e);
  endtask

  task automatic due_summed(input logic [7:0] b);
    frame_sum = frame_sum + b;
    due_plain(b, 1'b0);
  endtask

  // expand one body item into its frame bytes
  task automatic predict_frame_bytes(input logic [7:0] b, input logic last);
    logic [PRE_W-1:0] leaders;
    if (body_pos == POS_CTRL) begin
      leaders   = (leaders_shadow > MAX_LEADERS) ? MAX_LEADERS : leaders_shadow;
      frame_sum = 8'h00;
      repeat (leaders) due_plain(LEADER_BYTE, 1'b0);
      due_summed(START_MARK);
      for (int i = 0; i < 6; i++) due_summed(addr_shadow[8*i +: 8]);
      due_summed(START_MARK);
      due_summed(b);
      body_pos = POS_LEN;
    end else if (body_pos == POS_LEN) begin
      due_summed(b);
      body_pos = POS_DATA;
    end else begin
      due_summed(b + DATA_OFFSET);
    end
    // trailer closes the frame
    if (last) begin
      due_plain(frame_sum, 1'b0);
      due_plain(END_MARK, 1'b1);
      body_pos  = POS_CTRL;
      frame_sum = 8'h00;
      frames_closed++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      addr_shadow    = '0;
      leaders_shadow = PREAMBLE_RST;
      body_pos       = POS_CTRL;
      frame_sum      = 8'h00;
      mismatches     = 0;
      bytes_checked  = 0;
      frames_closed  = 0;
      frame_bytes_due.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_STATION_ADDR:   addr_shadow = cfg_data;
          CFG_PREAMBLE_COUNT: leaders_shadow = cfg_data[PRE_W-1:0];
          default: ;
        endcase
      end
      // body item in
      if (body_mon.valid && body_mon.ready) begin
        predict_frame_bytes(body_mon.body_byte, body_mon.is_last);
      end
      // frame byte out
      if (frame_mon.valid && frame_mon.ready) begin
        bytes_checked++;
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected frame byte %02h end %0b, nothing predicted",
                   $time, frame_mon.frame_byte, frame_mon.frame_end);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_mon.frame_byte !== want.fbyte) begin
            $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                     $time, want.fbyte, frame_mon.frame_byte);
            mismatches++;
          end
          if (frame_mon.frame_end !== want.fend) begin
            $display("%0t: frame_end mismatch: expected %0b, got %0b (byte %02h)",
                     $time, want.fend, frame_mon.frame_end, want.fbyte);
            mismatches++;
          end
        end
      end
    end
    pending = frame_bytes_due.size();
  end

endmodule

// ===== sim/meter_frame_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_encoder_test: top of the frame encoder testbench
// Drives body items and register writes, throttles the frame side, and
// reports the verdict from the checker's count. Directed frames cover the
// byte extremes, early close on control and length bytes, leader saturation
// and a write inside an open frame; random phases follow with changing
// registers, idle patterns and a long receiver hold.
// ----------------------------------------------------------------------------
module meter_frame_encoder_test;
  import mfe_pkg::*;

  localparam int ITEM_TARGET = 210;
  localparam int HOLD_CYCLES = 150;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 4;
  localparam int DRAIN       = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  int mismatches;
  int pending;
  int bytes_checked;
  int frames_closed;
  int items_sent;
  int reg_writes;
  int tx_gap_max;
  int rx_stall_max;
  logic hold_rx;

  body_if  body();
  frame_if frame();

  always #5 clk = ~clk;

  meter_frame_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .body      (body),
    .frame     (frame),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  meter_frame_encoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .body_mon      (body),
    .frame_mon     (frame),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .bytes_checked (bytes_checked),
    .frames_closed (frames_closed)
  );

  // offer one body item after a random gap, return at the next falling edge
  task automatic send_body(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      body.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body.valid     <= 1'b1;
    body.body_byte <= b;
    body.is_last   <= last;
    do @(posedge clk); while (!(body.valid && body.ready));
    @(negedge clk);
    items_sent++;
  endtask

  // stop offering and wait for every predicted frame byte
  task automatic wait_drained();
    body.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  // mostly well-formed frames, some closing early or with a wrong length
  task automatic send_random_frame();
    int kind;
    int n_data;
    logic [7:0] len;
    kind   = $urandom_range(0, 9);
    n_data = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    len    = n_data[7:0];
    if (kind == 0) begin
      send_body(8'($urandom_range(0, 255)), 1'b1);
    end else if (kind == 1) begin
      send_body(8'($urandom_range(0, 255)), 1'b0);
      send_body(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      if (kind == 2) len = 8'($urandom_range(0, 255));
      send_body(8'($urandom_range(0, 255)), 1'b0);
      send_body(len, n_data == 0);
      for (int i = 0; i < n_data; i++) begin
        send_body(8'($urandom_range(0, 255)), i == n_data - 1);
      end
    end
  endtask

  // frame side: random stalls, plus one long hold on request
  initial begin : frame_sink
    int stall;
    frame.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rx) begin
        frame.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        frame.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      frame.ready <= 1'b1;
      do @(posedge clk); while (!(frame.valid && frame.ready));
      @(negedge clk);
    end
  end

  // watchdog on handshake activity
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (body.valid && body.ready) || (frame.valid && frame.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles, %0d frame bytes outstanding",
             $time, QUIET_LIMIT, pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] addr;
    int n_frames;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    body.valid     = 1'b0;
    body.body_byte = 8'h00;
    body.is_last   = 1'b0;
    hold_rx        = 1'b0;
    items_sent     = 0;
    reg_writes     = 0;
    tx_gap_max     = 18;
    rx_stall_max   = 18;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: zero address, four leaders; data offset wraps
    send_body(8'h91, 1'b0);
    send_body(8'h02, 1'b0);
    send_body(8'hCD, 1'b0);
    send_body(8'h00, 1'b1);
    // close on the control byte, then on the length byte
    send_body(8'hFF, 1'b1);
    send_body(8'h00, 1'b0);
    send_body(8'hFF, 1'b1);

    // all-ones address, no leaders
    wait_drained();
    write_reg(CFG_STATION_ADDR, {ADDR_W{1'b1}});
    write_reg(CFG_PREAMBLE_COUNT, 48'd0);
    send_body(8'h11, 1'b0);
    send_body(8'h00, 1'b0);
    send_body(8'hFF, 1'b0);
    send_body(8'hCC, 1'b1);

    // leader count above four saturates
    wait_drained();
    write_reg(CFG_STATION_ADDR, 48'h0);
    write_reg(CFG_PREAMBLE_COUNT, 48'd7);
    send_body(8'h80, 1'b1);

    // registers rewritten inside an open frame apply to the next one
    wait_drained();
    write_reg(CFG_STATION_ADDR, 48'h1234_5678_9ABC);
    write_reg(CFG_PREAMBLE_COUNT, 48'd5);
    send_body(START_MARK, 1'b0);
    send_body(END_MARK, 1'b0);
    wait_drained();
    write_reg(CFG_STATION_ADDR, 48'hA5A5_5A5A_C33C);
    write_reg(CFG_PREAMBLE_COUNT, 48'd3);
    send_body(8'h55, 1'b0);
    send_body(8'hAA, 1'b0);
    send_body(8'h33, 1'b1);
    send_body(8'h01, 1'b0);
    send_body(8'h01, 1'b0);
    send_body(8'h01, 1'b0);
    send_body(8'hFE, 1'b1);

    // random phases
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      wait_drained();
      addr[31:0]  = $urandom();
      addr[47:32] = 16'($urandom_range(0, 65535));
      if (phase % 3 != 2) write_reg(CFG_STATION_ADDR, addr);
      if (phase % 3 != 1) write_reg(CFG_PREAMBLE_COUNT, ADDR_W'($urandom_range(0, 7)));
      if (phase % 4 == 1) begin
        tx_gap_max   = 0;
        rx_stall_max = 0;
      end else begin
        tx_gap_max   = 18;
        rx_stall_max = 18;
      end
      // long receiver hold while the sender keeps pushing
      if (phase == 2) begin
        tx_gap_max = 0;
        hold_rx    = 1'b1;
      end
      n_frames = $urandom_range(3, 5);
      for (int f = 0; f < n_frames; f++) send_random_frame();
    end

    // drain
    wait_drained();
    repeat (DRAIN) @(negedge clk);
    $display("covered %0d body items in %0d frames, %0d frame bytes compared",
             items_sent, frames_closed, bytes_checked);
    $display("%0d register writes incl. leader counts 0 and 7, early closes, long output hold",
             reg_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
